### hdl/tkmb_pkg.sv
// shared types and constants of the top-k merit buffer
`default_nettype none
package tkmb_pkg;

	localparam int MERIT_W    = 17;
	localparam int TAG_PORT_W = 16;
	localparam int SLOT_W     = 4;
	localparam int COUNT_W    = 5;
	localparam int CUTOFF_W   = 18;

	// one in Q1.16 and the largest cutoff an 18-bit signed field holds
	localparam logic signed [CUTOFF_W:0]   ONE_Q16    = 19'sd65536;
	localparam logic signed [CUTOFF_W:0]   CUTOFF_MAX = 19'sd131071;

	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_INSERT = 2'd1,
		FUNC_READ   = 2'd2,
		FUNC_NOP    = 2'd3
	} func_t;

	typedef struct packed {
		logic insert;
		logic occupied;
		logic last;
	} cell_ctrl_t;

endpackage
`default_nettype wire

### hdl/tkmb_cell.sv
// one slot of the sorted chain: compare against the new merit, hold, load or shift
`default_nettype none
module tkmb_cell #(
	parameter int TAG_W = 16
) (
	input  wire                                clk,
	input  wire tkmb_pkg::cell_ctrl_t          ctrl,
	input  wire  [tkmb_pkg::MERIT_W-1:0]       new_merit,
	input  wire  [TAG_W-1:0]                   new_tag,
	input  wire                                prev_at,
	input  wire  [tkmb_pkg::MERIT_W-1:0]       prev_merit,
	input  wire  [TAG_W-1:0]                   prev_tag,
	output logic                               at,
	output logic                               first,
	output logic [tkmb_pkg::MERIT_W-1:0]       merit,
	output logic [TAG_W-1:0]                   tag
);

	logic [tkmb_pkg::MERIT_W-1:0] merit_q;
	logic [TAG_W-1:0]             tag_q;

	// new item lands at or before this slot; free slots always accept
	always_comb begin
		if (ctrl.occupied) begin
			at = (new_merit > merit_q) || (ctrl.last && (new_merit >= merit_q));
		end else begin
			at = 1'b1;
		end
		first = at && !prev_at;
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert && prev_at) begin
			merit_q <= prev_merit;
			tag_q   <= prev_tag;
		end else if (ctrl.insert && first) begin
			merit_q <= new_merit;
			tag_q   <= new_tag;
		end
	end

	assign merit = merit_q;
	assign tag   = tag_q;

endmodule
`default_nettype wire

### hdl/top_k_merit_buffer_unit.sv
// top level of the top-k merit buffer: cell chain, counters, cutoff and output register
`default_nettype none
// Keeps the best DEPTH (merit, tag) entries sorted by descending merit in a row
// of compare-and-shift cells. Every operation (clear, insert, read next, no-op)
// gives one result item from the output register in the cycle after it is
// accepted; a new item is taken in every cycle while the output register
// is empty or being emptied, so the block sustains one item per cycle and
// holds off input only while a result sits stalled. All slots compare against
// the incoming merit in parallel and shift toward the tail in that same cycle.
// Stored entries need no clearing after reset: only slots below the entry
// count are ever compared or read.
module top_k_merit_buffer_unit #(
	parameter int DEPTH    = 16,
	parameter int TAG_BITS = 16
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      in_valid,
	output logic                                     in_stall,
	input  wire  [1:0]                               func,
	input  wire  [tkmb_pkg::MERIT_W-1:0]             new_merit,
	input  wire  [tkmb_pkg::TAG_PORT_W-1:0]          entry_tag,
	output logic                                     out_valid,
	input  wire                                      out_stall,
	output logic                                     done_ok,
	output logic [tkmb_pkg::SLOT_W-1:0]              slot,
	output logic [tkmb_pkg::MERIT_W-1:0]             out_merit,
	output logic [tkmb_pkg::TAG_PORT_W-1:0]          out_tag,
	output logic [tkmb_pkg::COUNT_W-1:0]             entry_count,
	output logic signed [tkmb_pkg::CUTOFF_W-1:0]     cutoff
);

	localparam int TW = (TAG_BITS < tkmb_pkg::TAG_PORT_W) ? TAG_BITS : tkmb_pkg::TAG_PORT_W;
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [CW-1:0]                        count_q;
	logic [CW-1:0]                        rp_q;
	logic signed [tkmb_pkg::CUTOFF_W-1:0] cut_q;

	logic                                 out_valid_q;
	logic                                 done_ok_q;
	logic [tkmb_pkg::SLOT_W-1:0]          slot_q;
	logic [tkmb_pkg::MERIT_W-1:0]         out_merit_q;
	logic [tkmb_pkg::TAG_PORT_W-1:0]      out_tag_q;
	logic [tkmb_pkg::COUNT_W-1:0]         entry_count_q;
	logic signed [tkmb_pkg::CUTOFF_W-1:0] cutoff_q;

	logic                                 acc;
	logic                                 do_insert;
	tkmb_pkg::func_t                      op;

	logic [tkmb_pkg::MERIT_W-1:0] merit_c [DEPTH];
	logic [TW-1:0]                tag_c   [DEPTH];
	logic [DEPTH-1:0]             at_c;
	logic [DEPTH-1:0]             first_c;

	assign in_stall  = out_valid_q && out_stall;
	assign acc       = in_valid && !in_stall;
	assign op        = tkmb_pkg::func_t'(func);
	assign do_insert = acc && (op == tkmb_pkg::FUNC_INSERT);

	// cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CW-1:0] IDX  = CW'(i);
		localparam logic [CW-1:0] NEXT = CW'(i + 1);
		tkmb_pkg::cell_ctrl_t     ctrl;
		logic                     p_at;
		logic [tkmb_pkg::MERIT_W-1:0] p_merit;
		logic [TW-1:0]            p_tag;

		assign ctrl.insert   = do_insert;
		assign ctrl.occupied = IDX < count_q;
		assign ctrl.last     = NEXT == count_q;

		if (i == 0) begin : g_head
			assign p_at    = 1'b0;
			assign p_merit = '0;
			assign p_tag   = '0;
		end else begin : g_link
			assign p_at    = at_c[i-1];
			assign p_merit = merit_c[i-1];
			assign p_tag   = tag_c[i-1];
		end

		tkmb_cell #(.TAG_W(TW)) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.new_merit  (new_merit),
			.new_tag    (entry_tag[TW-1:0]),
			.prev_at    (p_at),
			.prev_merit (p_merit),
			.prev_tag   (p_tag),
			.at         (at_c[i]),
			.first      (first_c[i]),
			.merit      (merit_c[i]),
			.tag        (tag_c[i])
		);
	end

	// insert position, read select and cutoff candidate
	logic [IW-1:0]                        ins_pos;
	logic                                 ins_kept;
	logic                                 rd_ok;
	logic [tkmb_pkg::MERIT_W-1:0]         rd_merit;
	logic [TW-1:0]                        rd_tag;
	logic signed [tkmb_pkg::CUTOFF_W:0]   cut_raw;
	logic signed [tkmb_pkg::CUTOFF_W-1:0] cut_new;

	always_comb begin
		ins_pos  = '0;
		rd_merit = '0;
		rd_tag   = '0;
		rd_ok    = rp_q < count_q;
		for (int i = 0; i < DEPTH; i++) begin
			if (first_c[i]) begin
				ins_pos = ins_pos | IW'(i);
			end
			if (rd_ok && (rp_q == CW'(i))) begin
				rd_merit = rd_merit | merit_c[i];
				rd_tag   = rd_tag | tag_c[i];
			end
		end
		// with all slots full and the merit below the tail, no slot takes it
		ins_kept = at_c[DEPTH-1];
		cut_raw  = $signed({1'b0, new_merit, 1'b0}) - tkmb_pkg::ONE_Q16;
		if (cut_raw > tkmb_pkg::CUTOFF_MAX) begin
			cut_new = tkmb_pkg::CUTOFF_MAX[tkmb_pkg::CUTOFF_W-1:0];
		end else begin
			cut_new = cut_raw[tkmb_pkg::CUTOFF_W-1:0];
		end
	end

	// next state and result of the item at the input
	logic [CW-1:0]                        count_d;
	logic [CW-1:0]                        rp_d;
	logic signed [tkmb_pkg::CUTOFF_W-1:0] cut_d;
	logic                                 ok_d;
	logic [tkmb_pkg::SLOT_W-1:0]          slot_d;
	logic [tkmb_pkg::MERIT_W-1:0]         om_d;
	logic [tkmb_pkg::TAG_PORT_W-1:0]      ot_d;

	always_comb begin
		count_d = count_q;
		rp_d    = rp_q;
		cut_d   = cut_q;
		ok_d    = 1'b0;
		slot_d  = '0;
		om_d    = '0;
		ot_d    = '0;
		case (op)
			tkmb_pkg::FUNC_CLEAR: begin
				count_d = '0;
				rp_d    = '0;
				cut_d   = '0;
				ok_d    = 1'b1;
			end
			tkmb_pkg::FUNC_INSERT: begin
				if (ins_kept) begin
					ok_d   = 1'b1;
					slot_d = tkmb_pkg::SLOT_W'(ins_pos);
					if (count_q != DEPTH_C) begin
						count_d = count_q + 1'b1;
					end
					if (first_c[0]) begin
						cut_d = cut_new;
					end
				end
			end
			tkmb_pkg::FUNC_READ: begin
				if (rd_ok) begin
					ok_d   = 1'b1;
					slot_d = tkmb_pkg::SLOT_W'(rp_q);
					om_d   = rd_merit;
					ot_d   = tkmb_pkg::TAG_PORT_W'(rd_tag);
					rp_d   = rp_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rp_q        <= '0;
			cut_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q     <= count_d;
				rp_q        <= rp_d;
				cut_q       <= cut_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			done_ok_q     <= ok_d;
			slot_q        <= slot_d;
			out_merit_q   <= om_d;
			out_tag_q     <= ot_d;
			entry_count_q <= tkmb_pkg::COUNT_W'(count_d);
			cutoff_q      <= cut_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign done_ok     = done_ok_q;
	assign slot        = slot_q;
	assign out_merit   = out_merit_q;
	assign out_tag     = out_tag_q;
	assign entry_count = entry_count_q;
	assign cutoff      = cutoff_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above depth");

	a_rp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= count_q)
		else $error("read pointer beyond stored entries");

	a_one_slot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_c))
		else $error("more than one cell claims the new entry");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input held off with no result waiting");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (op == tkmb_pkg::FUNC_CLEAR)) |=> (out_valid && done_ok && (count_q == '0)))
		else $error("clear did not empty the buffer");
`endif

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// self-checking testbench for the top-k merit buffer unit
`timescale 1ns / 1ps

module testbench;

	localparam int DEPTH = 16;
	localparam int HOLD_CYCLES = 60;
	localparam int RANDOM_ITEMS = 400;
	localparam int MERIT_W = tkmb_pkg::MERIT_W;
	localparam int TAG_PORT_W = tkmb_pkg::TAG_PORT_W;
	localparam int SLOT_W = tkmb_pkg::SLOT_W;
	localparam int COUNT_W = tkmb_pkg::COUNT_W;
	localparam int CUTOFF_W = tkmb_pkg::CUTOFF_W;

	typedef struct packed {
		logic                       ok;
		logic [SLOT_W-1:0]          slot;
		logic [MERIT_W-1:0]         merit;
		logic [TAG_PORT_W-1:0]      tag;
		logic [COUNT_W-1:0]         count;
		logic signed [CUTOFF_W-1:0] cutoff;
	} outcome_t;

	typedef struct packed {
		tkmb_pkg::func_t       f;
		logic [MERIT_W-1:0]    m;
		logic [TAG_PORT_W-1:0] t;
		logic                  typed;
		outcome_t              want;
	} plan_row_t;

	typedef enum {PH_QUIET, PH_SENDER_GAPS, PH_RECEIVER_STALLS, PH_BOTH, PH_HOLD} phase_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] func;
	logic [MERIT_W-1:0] new_merit;
	logic [TAG_PORT_W-1:0] entry_tag;
	logic out_valid;
	logic out_stall;
	logic done_ok;
	logic [SLOT_W-1:0] slot;
	logic [MERIT_W-1:0] out_merit;
	logic [TAG_PORT_W-1:0] out_tag;
	logic [COUNT_W-1:0] entry_count;
	logic signed [CUTOFF_W-1:0] cutoff;

	// own copy of the sorted store
	logic [MERIT_W-1:0] ranked_merit [DEPTH];
	logic [TAG_PORT_W-1:0] ranked_tag [DEPTH];
	int unsigned ranked_count;
	int unsigned walk_ptr;
	logic signed [CUTOFF_W-1:0] cutoff_now;

	outcome_t pending_outcomes[$];
	plan_row_t plan[$];
	int unsigned mismatch_count = 0;
	int unsigned items_taken = 0;
	int unsigned send_pct = 0;
	int unsigned stall_pct = 0;
	logic hold_go = 1'b0;
	logic [MERIT_W-1:0] last_merit = '0;

	top_k_merit_buffer_unit #(
		.DEPTH(DEPTH),
		.TAG_BITS(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.new_merit(new_merit),
		.entry_tag(entry_tag),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.done_ok(done_ok),
		.slot(slot),
		.out_merit(out_merit),
		.out_tag(out_tag),
		.entry_count(entry_count),
		.cutoff(cutoff)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic signed [CUTOFF_W-1:0] cutoff_for(logic [MERIT_W-1:0] m);
		int c;
		c = 2 * int'(m) - int'(tkmb_pkg::ONE_Q16);
		if (c > int'(tkmb_pkg::CUTOFF_MAX))
			c = int'(tkmb_pkg::CUTOFF_MAX);
		return c[CUTOFF_W-1:0];
	endfunction

	function automatic outcome_t outcome(bit ok, int s, int m, int t, int c, int cut);
		outcome_t o;
		o.ok = ok;
		o.slot = s[SLOT_W-1:0];
		o.merit = m[MERIT_W-1:0];
		o.tag = t[TAG_PORT_W-1:0];
		o.count = c[COUNT_W-1:0];
		o.cutoff = cut[CUTOFF_W-1:0];
		return o;
	endfunction

	// applies one operation to the local copy of the store and returns its result item
	function automatic outcome_t predict_buffer_op(tkmb_pkg::func_t f,
		logic [MERIT_W-1:0] m, logic [TAG_PORT_W-1:0] t);
		outcome_t o;
		int unsigned pos;
		bit found;
		o = '0;
		case (f)
			tkmb_pkg::FUNC_CLEAR: begin
				ranked_count = 0;
				walk_ptr = 0;
				cutoff_now = '0;
				o.ok = 1'b1;
			end
			tkmb_pkg::FUNC_INSERT: begin
				if (ranked_count == 0) begin
					ranked_merit[0] = m;
					ranked_tag[0] = t;
					ranked_count = 1;
					cutoff_now = cutoff_for(m);
					o.ok = 1'b1;
				end else if (m < ranked_merit[ranked_count-1]) begin
					// below the tail: append if there is room, else drop
					if (ranked_count < DEPTH) begin
						ranked_merit[ranked_count] = m;
						ranked_tag[ranked_count] = t;
						o.ok = 1'b1;
						o.slot = ranked_count[SLOT_W-1:0];
						ranked_count++;
					end
				end else begin
					pos = ranked_count - 1;
					found = 1'b0;
					for (int j = 0; j + 1 < ranked_count; j++) begin
						if (!found && m > ranked_merit[j]) begin
							pos = j;
							found = 1'b1;
						end
					end
					if (ranked_count >= DEPTH)
						ranked_count = DEPTH - 1;
					if (pos == 0)
						cutoff_now = cutoff_for(m);
					for (int j = ranked_count; j > pos; j--) begin
						ranked_merit[j] = ranked_merit[j-1];
						ranked_tag[j] = ranked_tag[j-1];
					end
					ranked_merit[pos] = m;
					ranked_tag[pos] = t;
					ranked_count++;
					o.ok = 1'b1;
					o.slot = pos[SLOT_W-1:0];
				end
			end
			tkmb_pkg::FUNC_READ: begin
				if (walk_ptr < ranked_count) begin
					o.ok = 1'b1;
					o.slot = walk_ptr[SLOT_W-1:0];
					o.merit = ranked_merit[walk_ptr];
					o.tag = ranked_tag[walk_ptr];
					walk_ptr++;
				end
			end
			default: ;
		endcase
		o.count = ranked_count[COUNT_W-1:0];
		o.cutoff = cutoff_now;
		return o;
	endfunction

	function automatic logic [MERIT_W-1:0] pick_merit();
		int unsigned r;
		logic [MERIT_W-1:0] m;
		r = $urandom_range(99);
		if (r < 15)
			m = last_merit;
		else if (r < 30) begin
			case ($urandom_range(5))
				0: m = 17'd0;
				1: m = 17'd32768;
				2: m = 17'd65535;
				3: m = 17'd65536;
				4: m = 17'd65537;
				default: m = 17'h1FFFF;
			endcase
		end else if (r < 90)
			m = MERIT_W'($urandom_range(65536));
		else
			m = MERIT_W'($urandom_range(17'h1FFFF));
		last_merit = m;
		return m;
	endfunction

	function automatic logic [TAG_PORT_W-1:0] pick_tag();
		return TAG_PORT_W'($urandom_range(16'hFFFF));
	endfunction

	task automatic set_phase(phase_t ph);
		case (ph)
			PH_SENDER_GAPS: begin send_pct = 58; stall_pct <= 0; end
			PH_RECEIVER_STALLS: begin send_pct = 0; stall_pct <= 58; end
			PH_BOTH: begin send_pct = 14; stall_pct <= 14; end
			default: begin send_pct = 0; stall_pct <= 0; end
		endcase
		hold_go <= (ph == PH_HOLD);
	endtask

	task automatic add_row(tkmb_pkg::func_t f, int m, int t);
		plan_row_t r;
		r = '0;
		r.f = f;
		r.m = m[MERIT_W-1:0];
		r.t = t[TAG_PORT_W-1:0];
		plan.push_back(r);
	endtask

	task automatic add_checked_row(tkmb_pkg::func_t f, int m, int t, outcome_t want);
		plan_row_t r;
		r.f = f;
		r.m = m[MERIT_W-1:0];
		r.t = t[TAG_PORT_W-1:0];
		r.typed = 1'b1;
		r.want = want;
		plan.push_back(r);
	endtask

	// presents one item and holds it until the block takes it
	task automatic offer(tkmb_pkg::func_t f, logic [MERIT_W-1:0] m,
		logic [TAG_PORT_W-1:0] t, bit typed, outcome_t want);
		outcome_t pred;
		bit took;
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		new_merit <= m;
		entry_tag <= t;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = !in_stall;
			if (took) begin
				pred = predict_buffer_op(f, m, t);
				pending_outcomes.push_back(typed ? want : pred);
				items_taken++;
			end
			@(posedge clk);
		end
	endtask

	task automatic compare_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// outputs are stable between the falling edge and the next rising edge
	always @(negedge clk) begin : check_results
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t ns: expected no item, got done_ok %0d slot %0d count %0d",
					$time, done_ok, slot, entry_count);
				mismatch_count++;
			end else begin
				want = pending_outcomes.pop_front();
				compare_field("done_ok", want.ok, done_ok);
				compare_field("slot", want.slot, slot);
				compare_field("out_merit", want.merit, out_merit);
				compare_field("out_tag", want.tag, out_tag);
				compare_field("entry_count", want.count, entry_count);
				compare_field("cutoff", $signed(want.cutoff), $signed(cutoff));
			end
		end
	end

	// receiver: random stalls, plus one long hold-off while the sender keeps going
	initial begin : receiver
		int unsigned hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_used) begin
				hold_left = HOLD_CYCLES;
				hold_used = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else
				out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin : stimulus
		int unsigned seq;
		int unsigned n;
		phase_t ph;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = tkmb_pkg::FUNC_CLEAR;
		new_merit = '0;
		entry_tag = '0;
		ranked_merit = '{default: '0};
		ranked_tag = '{default: '0};
		ranked_count = 0;
		walk_ptr = 0;
		cutoff_now = '0;
		seq = 0;

		add_checked_row(tkmb_pkg::FUNC_READ, 0, 0, outcome(0, 0, 0, 0, 0, 0));
		add_checked_row(tkmb_pkg::FUNC_NOP, 17'h1FFFF, 16'hFFFF, outcome(0, 0, 0, 0, 0, 0));
		add_checked_row(tkmb_pkg::FUNC_INSERT, 65536, 16'hFFFF, outcome(1, 0, 0, 0, 1, 65536));
		add_checked_row(tkmb_pkg::FUNC_INSERT, 0, 0, outcome(1, 1, 0, 0, 2, 65536));
		// merit just under 2.0: cutoff saturates
		add_checked_row(tkmb_pkg::FUNC_INSERT, 17'h1FFFF, 16'h5555,
			outcome(1, 0, 0, 0, 3, 131071));
		add_row(tkmb_pkg::FUNC_INSERT, 0, 16'h0001);
		add_row(tkmb_pkg::FUNC_INSERT, 65536, 16'hAAAA);
		add_checked_row(tkmb_pkg::FUNC_READ, 0, 0,
			outcome(1, 0, 17'h1FFFF, 16'h5555, 5, 131071));
		add_row(tkmb_pkg::FUNC_READ, 0, 0);
		add_row(tkmb_pkg::FUNC_INSERT, 98304, 16'h1234);
		add_row(tkmb_pkg::FUNC_READ, 0, 0);
		add_row(tkmb_pkg::FUNC_NOP, 12345, 16'h4321);
		add_checked_row(tkmb_pkg::FUNC_CLEAR, 17'h1FFFF, 16'hFFFF, outcome(1, 0, 0, 0, 0, 0));
		add_checked_row(tkmb_pkg::FUNC_INSERT, 0, 16'hFFFF, outcome(1, 0, 0, 0, 1, -65536));
		add_row(tkmb_pkg::FUNC_INSERT, 0, 16'h8000);
		add_row(tkmb_pkg::FUNC_READ, 0, 0);
		add_row(tkmb_pkg::FUNC_READ, 0, 0);
		add_checked_row(tkmb_pkg::FUNC_READ, 0, 0, outcome(0, 0, 0, 0, 2, -65536));
		add_row(tkmb_pkg::FUNC_INSERT, 32768, 16'h0F0F);
		add_row(tkmb_pkg::FUNC_READ, 0, 0);
		add_checked_row(tkmb_pkg::FUNC_CLEAR, 0, 0, outcome(1, 0, 0, 0, 0, 0));
		add_row(tkmb_pkg::FUNC_INSERT, 65535, 16'h7FFF);
		add_row(tkmb_pkg::FUNC_READ, 0, 0);

		set_phase(PH_QUIET);
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			offer(plan[i].f, plan[i].m, plan[i].t, plan[i].typed, plan[i].want);

		while (items_taken < plan.size() + RANDOM_ITEMS) begin
			seq++;
			ph = (seq == 2) ? PH_HOLD : phase_t'($urandom_range(3));
			set_phase(ph);
			if ($urandom_range(99) < 80) begin
				// fill run from empty, with reads mixed in, then walk the entries
				offer(tkmb_pkg::FUNC_CLEAR, pick_merit(), pick_tag(), 1'b0, '0);
				n = $urandom_range(3, 28);
				repeat (n) begin
					if ($urandom_range(99) < 20)
						offer(tkmb_pkg::FUNC_READ, pick_merit(), pick_tag(), 1'b0, '0);
					else
						offer(tkmb_pkg::FUNC_INSERT, pick_merit(), pick_tag(), 1'b0, '0);
				end
				n = $urandom_range(18);
				repeat (n)
					offer(tkmb_pkg::FUNC_READ, '0, pick_tag(), 1'b0, '0);
			end else begin
				n = $urandom_range(2, 10);
				repeat (n)
					offer(tkmb_pkg::func_t'($urandom_range(3)), pick_merit(), pick_tag(),
						1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		set_phase(PH_QUIET);
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : watchdog
		#(3_000_000);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

### sim.f
hdl/tkmb_pkg.sv
hdl/tkmb_cell.sv
hdl/top_k_merit_buffer_unit.sv
tb/sv/testbench.sv
